// ===== src/hdl_number_literal_lexer_defines.svh =====
// assertion macros for the lexer top level
`ifndef HDL_NUMBER_LITERAL_LEXER_DEFINES_SVH
`define HDL_NUMBER_LITERAL_LEXER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define HNL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define HNL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/hnl_pkg.sv =====
`timescale 1ns / 1ps

package hnl_pkg;

    // literal phases
    localparam logic [3:0] PH_START   = 4'd0;
    localparam logic [3:0] PH_FIRST   = 4'd1;
    localparam logic [3:0] PH_SPACE1  = 4'd2;
    localparam logic [3:0] PH_QUOTE   = 4'd3;
    localparam logic [3:0] PH_BASE    = 4'd4;
    localparam logic [3:0] PH_VFIRST  = 4'd5;
    localparam logic [3:0] PH_VALUE   = 4'd6;
    localparam logic [3:0] PH_FRAC1   = 4'd7;
    localparam logic [3:0] PH_FRAC    = 4'd8;
    localparam logic [3:0] PH_EXPSIGN = 4'd9;
    localparam logic [3:0] PH_EXP1    = 4'd10;
    localparam logic [3:0] PH_EXP     = 4'd11;

    // literal kinds
    localparam logic [2:0] K_UNKNOWN = 3'd0;
    localparam logic [2:0] K_REAL    = 3'd1;
    localparam logic [2:0] K_DEC     = 3'd2;
    localparam logic [2:0] K_OCT     = 3'd3;
    localparam logic [2:0] K_BIN     = 3'd4;
    localparam logic [2:0] K_HEX     = 3'd5;

    // flag bits
    localparam int F_SIGNED = 0;
    localparam int F_SIZE   = 1;
    localparam int F_BASE   = 2;
    localparam int F_VALUE  = 3;

    // error codes
    localparam logic [3:0] E_OK             = 4'd0;
    localparam logic [3:0] E_EXPECT_DIGIT   = 4'd1;
    localparam logic [3:0] E_SIZE_NONDEC    = 4'd2;
    localparam logic [3:0] E_SIZE_LEAD_ZERO = 4'd3;
    localparam logic [3:0] E_BAD_BASE       = 4'd4;
    localparam logic [3:0] E_BAD_DIGIT      = 4'd5;
    localparam logic [3:0] E_DEC_NONDEC     = 4'd6;
    localparam logic [3:0] E_BAD_DEC_XZ     = 4'd7;
    localparam logic [3:0] E_REAL_NONDEC    = 4'd8;

    // character roles
    localparam logic [1:0] R_SKIP  = 2'd0;
    localparam logic [1:0] R_FIRST = 2'd1;
    localparam logic [1:0] R_VALUE = 2'd2;
    localparam logic [1:0] R_REAL  = 2'd3;

    // special characters
    localparam logic [7:0] CH_UNDER   = 8'h5f;
    localparam logic [7:0] CH_DOT     = 8'h2e;
    localparam logic [7:0] CH_LOWER_S = 8'h73;
    localparam logic [7:0] CH_QMARK   = 8'h3f;
    localparam logic [7:0] CH_LOWER_E = 8'h65;

    // classified character passed from front to back
    typedef struct packed {
        logic [7:0] ch;
        logic       nul;
        logic       dig;
        logic       zero_dig;
        logic       d01;
        logic       d27;
        logic       d89;
        logic       hexlet;
        logic       space;
        logic       xz;
        logic       quote;
        logic       under;
        logic       dot;
        logic       s_ch;
        logic       is_e;
        logic       plus;
        logic       minus;
        logic [2:0] base_kind;
    } t_char_class;

endpackage

// ===== src/hnl_front.sv =====
`timescale 1ns / 1ps

module hnl_front
    import hnl_pkg::*;
(
    input  logic        i_valid,
    input  logic [7:0]  i_char_in,
    input  logic        i_at_end,
    input  logic        i_full,
    output logic        o_ready,
    output logic        o_push,
    output t_char_class o_item
);

    logic [7:0] c;

    // end of text reads as a nul character
    assign c = i_at_end ? 8'h00 : i_char_in;

    // input handshake into the queue
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // character classification
    always_comb begin
        o_item.ch       = c;
        o_item.nul      = (c == 8'h00);
        o_item.dig      = (c >= "0") && (c <= "9");
        o_item.zero_dig = (c == "0");
        o_item.d01      = (c == "0") || (c == "1");
        o_item.d27      = (c >= "2") && (c <= "7");
        o_item.d89      = (c == "8") || (c == "9");
        o_item.hexlet   = ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
        o_item.space    = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
        o_item.xz       = (c == "x") || (c == "X") || (c == "z") || (c == "Z")
                          || (c == CH_QMARK);
        o_item.quote    = (c == "'");
        o_item.under    = (c == CH_UNDER);
        o_item.dot      = (c == CH_DOT);
        o_item.s_ch     = (c == CH_LOWER_S) || (c == "S");
        o_item.is_e     = (c == CH_LOWER_E) || (c == "E");
        o_item.plus     = (c == "+");
        o_item.minus    = (c == "-");
        if ((c == "d") || (c == "D")) begin
            o_item.base_kind = K_DEC;
        end else if ((c == "b") || (c == "B")) begin
            o_item.base_kind = K_BIN;
        end else if ((c == "o") || (c == "O")) begin
            o_item.base_kind = K_OCT;
        end else if ((c == "h") || (c == "H")) begin
            o_item.base_kind = K_HEX;
        end else begin
            o_item.base_kind = K_UNKNOWN;
        end
    end

endmodule

// ===== src/hnl_queue.sv =====
`timescale 1ns / 1ps

module hnl_queue
    import hnl_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_char_class i_item,
    output logic        o_full,
    input  logic        i_pop,
    output logic        o_valid,
    output t_char_class o_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_char_class r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== src/hnl_back.sv =====
`timescale 1ns / 1ps

module hnl_back
    import hnl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    input  logic        i_q_valid,
    input  t_char_class i_item,
    output logic        o_pop,
    input  logic        i_ready,
    output logic        o_valid,
    output logic        o_consumed,
    output logic [1:0]  o_role,
    output logic [7:0]  o_value_char,
    output logic        o_done_res,
    output logic [3:0]  o_error_code,
    output logic [2:0]  o_kind,
    output logic        o_is_signed,
    output logic        o_has_size,
    output logic        o_has_base,
    output logic        o_has_value
);

    logic       r_strict;
    logic [3:0] r_phase, n_phase;
    logic [2:0] r_kind, n_kind;
    logic [3:0] r_flags, n_flags;
    logic       r_fhl, n_fhl;
    logic       r_flz, n_flz;
    logic [1:0] r_cnt, n_cnt;
    logic       r_xz, n_xz;

    logic       r_out_valid;
    logic       r_consumed;
    logic [1:0] r_role;
    logic [7:0] r_vch;
    logic       r_done;
    logic [3:0] r_err;
    logic [2:0] r_kind_out;
    logic [3:0] r_flags_out;

    logic       cons, done, ext, any;
    logic [1:0] role;
    logic [7:0] vch;
    logic [3:0] err;
    logic [3:0] ph;
    t_char_class it;

    assign it    = i_item;
    assign o_pop = i_q_valid && (!r_out_valid || i_ready);

    // digit check against the current base
    always_comb begin
        any = !r_strict;
        if (it.d01) begin
            ext = any || (r_kind == K_OCT) || (r_kind == K_HEX) || (r_kind == K_DEC)
                  || (r_kind == K_BIN);
        end else if (it.d27) begin
            ext = any || (r_kind == K_OCT) || (r_kind == K_HEX) || (r_kind == K_DEC);
        end else if (it.d89) begin
            ext = any || (r_kind == K_HEX) || (r_kind == K_DEC);
        end else if (it.hexlet) begin
            ext = any || (r_kind == K_HEX);
        end else if (it.xz) begin
            ext = any || (r_kind == K_OCT) || (r_kind == K_HEX) || (r_kind == K_BIN)
                  || (r_kind == K_DEC);
        end else begin
            ext = 1'b0;
        end
    end

    // phase step for one character
    always_comb begin
        cons    = 1'b0;
        role    = R_SKIP;
        vch     = 8'h00;
        done    = 1'b0;
        err     = E_OK;
        n_phase = r_phase;
        n_kind  = r_kind;
        n_flags = r_flags;
        n_fhl   = r_fhl;
        n_flz   = r_flz;
        n_cnt   = r_cnt;
        n_xz    = r_xz;
        ph      = (r_phase > PH_EXP) ? PH_START : r_phase;
        case (ph)
            PH_START: begin
                if (it.quote) begin
                    cons    = 1'b1;
                    n_phase = PH_QUOTE;
                end else if (it.dig) begin
                    cons    = 1'b1;
                    role    = R_FIRST;
                    vch     = it.ch;
                    n_flz   = it.zero_dig;
                    n_fhl   = 1'b0;
                    n_phase = PH_FIRST;
                end else begin
                    done = 1'b1;
                    err  = E_EXPECT_DIGIT;
                end
            end
            PH_FIRST, PH_SPACE1: begin
                if ((ph == PH_FIRST) && it.under) begin
                    cons = 1'b1;
                end else if ((ph == PH_FIRST) && (it.dig || it.hexlet)) begin
                    cons = 1'b1;
                    role = R_FIRST;
                    vch  = it.ch;
                    if (!it.dig) begin
                        n_fhl = 1'b1;
                    end
                end else if ((ph == PH_FIRST) && it.dot) begin
                    if (r_fhl) begin
                        done = 1'b1;
                        err  = E_REAL_NONDEC;
                    end else begin
                        cons    = 1'b1;
                        role    = R_REAL;
                        vch     = it.ch;
                        n_kind  = K_REAL;
                        n_phase = PH_FRAC1;
                    end
                end else if (it.space) begin
                    cons    = 1'b1;
                    n_phase = PH_SPACE1;
                end else if (it.quote) begin
                    if (r_fhl) begin
                        done = 1'b1;
                        err  = E_SIZE_NONDEC;
                    end else if (r_flz) begin
                        done = 1'b1;
                        err  = E_SIZE_LEAD_ZERO;
                    end else begin
                        cons            = 1'b1;
                        n_flags[F_SIZE] = 1'b1;
                        n_phase         = PH_QUOTE;
                    end
                end else begin
                    n_kind = K_DEC;
                    done   = 1'b1;
                    if (r_strict && r_fhl) begin
                        err = E_DEC_NONDEC;
                    end
                end
            end
            PH_QUOTE, PH_BASE: begin
                if ((ph == PH_QUOTE) && it.s_ch) begin
                    cons              = 1'b1;
                    n_flags[F_SIGNED] = 1'b1;
                    n_phase           = PH_BASE;
                end else if (it.base_kind == K_UNKNOWN) begin
                    done = 1'b1;
                    err  = E_BAD_BASE;
                end else begin
                    cons            = 1'b1;
                    n_kind          = it.base_kind;
                    n_flags[F_BASE] = 1'b1;
                    n_phase         = PH_VFIRST;
                end
            end
            PH_VFIRST: begin
                if (it.space) begin
                    cons = 1'b1;
                end else if (ext) begin
                    cons    = 1'b1;
                    role    = R_VALUE;
                    vch     = it.ch;
                    n_cnt   = 2'd1;
                    n_xz    = it.xz;
                    n_phase = PH_VALUE;
                end else begin
                    done = 1'b1;
                    if (r_strict) begin
                        err = E_BAD_DIGIT;
                    end
                end
            end
            PH_VALUE: begin
                if (it.under) begin
                    cons = 1'b1;
                end else if (ext) begin
                    cons = 1'b1;
                    role = R_VALUE;
                    vch  = it.ch;
                    if (r_cnt != 2'd3) begin
                        n_cnt = r_cnt + 2'd1;
                    end
                    if (it.xz) begin
                        n_xz = 1'b1;
                    end
                end else begin
                    done = 1'b1;
                    if (r_strict && !(it.nul || it.space)) begin
                        err = E_BAD_DIGIT;
                    end else if (r_strict && (r_kind == K_DEC) && r_xz && (r_cnt != 2'd1)) begin
                        err = E_BAD_DEC_XZ;
                    end else begin
                        n_flags[F_VALUE] = 1'b1;
                    end
                end
            end
            PH_FRAC1, PH_EXP1: begin
                if (it.dig) begin
                    cons    = 1'b1;
                    role    = R_REAL;
                    vch     = it.ch;
                    n_phase = (ph == PH_FRAC1) ? PH_FRAC : PH_EXP;
                end else begin
                    done = 1'b1;
                    err  = E_EXPECT_DIGIT;
                end
            end
            PH_FRAC, PH_EXP: begin
                if (it.under) begin
                    cons = 1'b1;
                end else if (it.dig) begin
                    cons = 1'b1;
                    role = R_REAL;
                    vch  = it.ch;
                end else if ((ph == PH_FRAC) && it.is_e) begin
                    cons    = 1'b1;
                    role    = R_REAL;
                    vch     = CH_LOWER_E;
                    n_phase = PH_EXPSIGN;
                end else begin
                    done = 1'b1;
                end
            end
            default: begin
                // exponent sign
                if (it.plus) begin
                    cons    = 1'b1;
                    n_phase = PH_EXP1;
                end else if (it.minus) begin
                    cons    = 1'b1;
                    role    = R_REAL;
                    vch     = it.ch;
                    n_phase = PH_EXP1;
                end else if (it.dig) begin
                    cons    = 1'b1;
                    role    = R_REAL;
                    vch     = it.ch;
                    n_phase = PH_EXP;
                end else begin
                    done = 1'b1;
                    err  = E_EXPECT_DIGIT;
                end
            end
        endcase
    end

    // strict check register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strict <= 1'b0;
        end else if (i_cfg_we) begin
            r_strict <= i_cfg_data;
        end
    end

    // literal state, back to reset values once a literal completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (o_pop && done)) begin
            r_phase <= PH_START;
            r_kind  <= K_UNKNOWN;
            r_flags <= '0;
            r_fhl   <= 1'b0;
            r_flz   <= 1'b0;
            r_cnt   <= 2'd0;
            r_xz    <= 1'b0;
        end else if (o_pop) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_flags <= n_flags;
            r_fhl   <= n_fhl;
            r_flz   <= n_flz;
            r_cnt   <= n_cnt;
            r_xz    <= n_xz;
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_consumed  <= cons;
            r_role      <= role;
            r_vch       <= vch;
            r_done      <= done;
            r_err       <= err;
            r_kind_out  <= n_kind;
            r_flags_out <= n_flags;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_consumed   = r_consumed;
    assign o_role       = r_role;
    assign o_value_char = r_vch;
    assign o_done_res   = r_done;
    assign o_error_code = r_err;
    assign o_kind       = r_kind_out;
    assign o_is_signed  = r_flags_out[F_SIGNED];
    assign o_has_size   = r_flags_out[F_SIZE];
    assign o_has_base   = r_flags_out[F_BASE];
    assign o_has_value  = r_flags_out[F_VALUE];

endmodule

// ===== src/hdl_number_literal_lexer.sv =====
// Number-literal lexer: takes one character per transfer and returns one result per
// character, giving consumption, value character, completion, kind, flags and error
// code. It sustains one character per clock cycle while the consumer does not stall;
// each character is registered in the queue, and its result in the output register. A
// character queue of QUEUE_DEPTH entries sits between the classifier and the phase
// logic, and an output register holds a result while the consumer stalls. A
// character that ends a literal is not consumed and must be sent again. No start-up
// pass is needed after reset. The user writes the strict-check register through
// i_cfg_we / i_cfg_data only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps

`include "hdl_number_literal_lexer_defines.svh"

module hdl_number_literal_lexer
    import hnl_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_at_end,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_consumed,
    output logic [1:0] o_role,
    output logic [7:0] o_value_char,
    output logic       o_done_res,
    output logic [3:0] o_error_code,
    output logic [2:0] o_kind,
    output logic       o_is_signed,
    output logic       o_has_size,
    output logic       o_has_base,
    output logic       o_has_value
);

    logic        push, full, q_valid, pop;
    t_char_class front_item, q_item;

    // classifier
    hnl_front u_front (
        .i_valid   (i_valid),
        .i_char_in (i_char_in),
        .i_at_end  (i_at_end),
        .i_full    (full),
        .o_ready   (o_ready),
        .o_push    (push),
        .o_item    (front_item)
    );

    // character queue
    hnl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // phase logic and output register
    hnl_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_q_valid    (q_valid),
        .i_item       (q_item),
        .o_pop        (pop),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_consumed   (o_consumed),
        .o_role       (o_role),
        .o_value_char (o_value_char),
        .o_done_res   (o_done_res),
        .o_error_code (o_error_code),
        .o_kind       (o_kind),
        .o_is_signed  (o_is_signed),
        .o_has_size   (o_has_size),
        .o_has_base   (o_has_base),
        .o_has_value  (o_has_value)
    );

    // an error always ends the literal and leaves the character unconsumed
    `HNL_ASSERT_NOW(a_err_done, i_clk, i_rst_n, o_valid && (o_error_code != E_OK), o_done_res && !o_consumed, "error without completion")
    // a value character is only produced for a consumed character
    `HNL_ASSERT_NOW(a_role_cons, i_clk, i_rst_n, o_valid && (o_role != R_SKIP), o_consumed, "role on unconsumed character")
    // skipped characters add nothing to the value text
    `HNL_ASSERT_NOW(a_skip_zero, i_clk, i_rst_n, o_valid && (o_role == R_SKIP), o_value_char == 8'h00, "value character on skipped character")
    // a popped character is always in the output register next cycle
    `HNL_ASSERT_NEXT(a_pop_out, i_clk, i_rst_n, pop, o_valid, "popped character lost")

endmodule

// ===== dv/hdl_number_literal_lexer_tb.sv =====
`timescale 1ns / 1ps

module hdl_number_literal_lexer_tb;
    import hnl_pkg::*;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          HOLD_CYCLES = 80;
    localparam logic [7:0]  CH_QUOTE    = 8'h27;
    localparam logic [7:0]  CH_NUL      = 8'h00;

    // one result as the block reports it
    typedef struct packed {
        logic       consumed;
        logic [1:0] role;
        logic [7:0] vchar;
        logic       done;
        logic [3:0] err;
        logic [2:0] kind;
        logic       sgn;
        logic       sized;
        logic       based;
        logic       valued;
    } t_lex_result;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic       i_cfg_data = 1'b0;
    logic       i_valid    = 1'b0;
    logic [7:0] i_char_in  = 8'h00;
    logic       i_at_end   = 1'b0;
    logic       i_ready    = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic       o_consumed;
    logic [1:0] o_role;
    logic [7:0] o_value_char;
    logic       o_done_res;
    logic [3:0] o_error_code;
    logic [2:0] o_kind;
    logic       o_is_signed;
    logic       o_has_size;
    logic       o_has_base;
    logic       o_has_value;

    // lexer state as predicted
    logic       strict_mode   = 1'b0;
    logic [3:0] lex_phase     = PH_START;
    logic [2:0] lex_kind      = K_UNKNOWN;
    logic [3:0] lex_flags     = 4'h0;
    logic       lex_first_let = 1'b0;
    logic       lex_first_zero = 1'b0;
    logic [1:0] lex_value_cnt = 2'd0;
    logic       lex_value_xz  = 1'b0;

    t_lex_result pending_results[$];

    int  chars_sent     = 0;
    int  results_seen   = 0;
    int  literals_done  = 0;
    int  literals_error = 0;
    int  strict_writes  = 0;
    int  mismatches     = 0;
    int  cycle_count    = 0;
    int  hold_requests  = 0;
    int  holds_served   = 0;
    int  hold_left      = 0;
    bit  idle_on        = 1'b1;

    hdl_number_literal_lexer u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_char_in    (i_char_in),
        .i_at_end     (i_at_end),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_consumed   (o_consumed),
        .o_role       (o_role),
        .o_value_char (o_value_char),
        .o_done_res   (o_done_res),
        .o_error_code (o_error_code),
        .o_kind       (o_kind),
        .o_is_signed  (o_is_signed),
        .o_has_size   (o_has_size),
        .o_has_base   (o_has_base),
        .o_has_value  (o_has_value)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // character classes
    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_hex_letter(input logic [7:0] c);
        return (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_xz(input logic [7:0] c);
        return c == "x" || c == "X" || c == "z" || c == "Z" || c == CH_QMARK;
    endfunction

    // digit accepted for the current base, all digits when not strict
    function automatic logic digit_in_base(input logic [7:0] c);
        logic any;
        any = !strict_mode;
        if (c == "0" || c == "1" || is_xz(c))
            return any || lex_kind == K_OCT || lex_kind == K_HEX || lex_kind == K_DEC ||
                   lex_kind == K_BIN;
        if (c >= "2" && c <= "7")
            return any || lex_kind == K_OCT || lex_kind == K_HEX || lex_kind == K_DEC;
        if (c == "8" || c == "9")
            return any || lex_kind == K_HEX || lex_kind == K_DEC;
        if (is_hex_letter(c))
            return any || lex_kind == K_HEX;
        return 1'b0;
    endfunction

    // next result of the lexer; advances the predicted state
    function automatic t_lex_result predict_lex_result(input logic [7:0] raw,
                                                       input logic ended);
        t_lex_result r;
        logic [7:0]  c;
        logic [3:0]  ph;
        logic [2:0]  base_k;
        c  = ended ? CH_NUL : raw;
        r  = '0;
        ph = (lex_phase > PH_EXP) ? PH_START : lex_phase;
        case (ph)
            PH_START: begin
                if (c == CH_QUOTE) begin
                    r.consumed = 1'b1;
                    lex_phase  = PH_QUOTE;
                end else if (is_digit(c)) begin
                    r.consumed     = 1'b1;
                    r.role         = R_FIRST;
                    r.vchar        = c;
                    lex_first_zero = (c == "0");
                    lex_first_let  = 1'b0;
                    lex_phase      = PH_FIRST;
                end else begin
                    r.done = 1'b1;
                    r.err  = E_EXPECT_DIGIT;
                end
            end
            PH_FIRST, PH_SPACE1: begin
                if (ph == PH_FIRST && c == CH_UNDER) begin
                    r.consumed = 1'b1;
                end else if (ph == PH_FIRST && (is_digit(c) || is_hex_letter(c))) begin
                    r.consumed = 1'b1;
                    r.role     = R_FIRST;
                    r.vchar    = c;
                    if (!is_digit(c))
                        lex_first_let = 1'b1;
                end else if (ph == PH_FIRST && c == CH_DOT) begin
                    if (lex_first_let) begin
                        r.done = 1'b1;
                        r.err  = E_REAL_NONDEC;
                    end else begin
                        r.consumed = 1'b1;
                        r.role     = R_REAL;
                        r.vchar    = c;
                        lex_kind   = K_REAL;
                        lex_phase  = PH_FRAC1;
                    end
                end else if (is_blank(c)) begin
                    r.consumed = 1'b1;
                    lex_phase  = PH_SPACE1;
                end else if (c == CH_QUOTE) begin
                    if (lex_first_let) begin
                        r.done = 1'b1;
                        r.err  = E_SIZE_NONDEC;
                    end else if (lex_first_zero) begin
                        r.done = 1'b1;
                        r.err  = E_SIZE_LEAD_ZERO;
                    end else begin
                        r.consumed        = 1'b1;
                        lex_flags[F_SIZE] = 1'b1;
                        lex_phase         = PH_QUOTE;
                    end
                end else begin
                    lex_kind = K_DEC;
                    r.done   = 1'b1;
                    if (strict_mode && lex_first_let)
                        r.err = E_DEC_NONDEC;
                end
            end
            PH_QUOTE, PH_BASE: begin
                if (ph == PH_QUOTE && (c == CH_LOWER_S || c == "S")) begin
                    r.consumed          = 1'b1;
                    lex_flags[F_SIGNED] = 1'b1;
                    lex_phase           = PH_BASE;
                end else begin
                    case (c)
                        "d", "D": base_k = K_DEC;
                        "b", "B": base_k = K_BIN;
                        "o", "O": base_k = K_OCT;
                        "h", "H": base_k = K_HEX;
                        default:  base_k = K_UNKNOWN;
                    endcase
                    if (base_k == K_UNKNOWN) begin
                        r.done = 1'b1;
                        r.err  = E_BAD_BASE;
                    end else begin
                        r.consumed        = 1'b1;
                        lex_kind          = base_k;
                        lex_flags[F_BASE] = 1'b1;
                        lex_phase         = PH_VFIRST;
                    end
                end
            end
            PH_VFIRST: begin
                if (is_blank(c)) begin
                    r.consumed = 1'b1;
                end else if (digit_in_base(c)) begin
                    r.consumed    = 1'b1;
                    r.role        = R_VALUE;
                    r.vchar       = c;
                    lex_value_cnt = 2'd1;
                    lex_value_xz  = is_xz(c);
                    lex_phase     = PH_VALUE;
                end else begin
                    r.done = 1'b1;
                    if (strict_mode)
                        r.err = E_BAD_DIGIT;
                end
            end
            PH_VALUE: begin
                if (c == CH_UNDER) begin
                    r.consumed = 1'b1;
                end else if (digit_in_base(c)) begin
                    r.consumed = 1'b1;
                    r.role     = R_VALUE;
                    r.vchar    = c;
                    if (lex_value_cnt != 2'd3)
                        lex_value_cnt = lex_value_cnt + 2'd1;
                    if (is_xz(c))
                        lex_value_xz = 1'b1;
                end else begin
                    r.done = 1'b1;
                    if (strict_mode && !(c == CH_NUL || is_blank(c)))
                        r.err = E_BAD_DIGIT;
                    else if (strict_mode && lex_kind == K_DEC && lex_value_xz &&
                             lex_value_cnt != 2'd1)
                        r.err = E_BAD_DEC_XZ;
                    else
                        lex_flags[F_VALUE] = 1'b1;
                end
            end
            PH_FRAC1, PH_EXP1: begin
                if (is_digit(c)) begin
                    r.consumed = 1'b1;
                    r.role     = R_REAL;
                    r.vchar    = c;
                    lex_phase  = (ph == PH_FRAC1) ? PH_FRAC : PH_EXP;
                end else begin
                    r.done = 1'b1;
                    r.err  = E_EXPECT_DIGIT;
                end
            end
            PH_FRAC, PH_EXP: begin
                if (c == CH_UNDER) begin
                    r.consumed = 1'b1;
                end else if (is_digit(c)) begin
                    r.consumed = 1'b1;
                    r.role     = R_REAL;
                    r.vchar    = c;
                end else if (ph == PH_FRAC && (c == "e" || c == "E")) begin
                    r.consumed = 1'b1;
                    r.role     = R_REAL;
                    r.vchar    = CH_LOWER_E;
                    lex_phase  = PH_EXPSIGN;
                end else begin
                    r.done = 1'b1;
                end
            end
            default: begin
                // exponent sign; a plus adds nothing to the value text
                if (c == "+") begin
                    r.consumed = 1'b1;
                    lex_phase  = PH_EXP1;
                end else if (c == "-") begin
                    r.consumed = 1'b1;
                    r.role     = R_REAL;
                    r.vchar    = c;
                    lex_phase  = PH_EXP1;
                end else if (is_digit(c)) begin
                    r.consumed = 1'b1;
                    r.role     = R_REAL;
                    r.vchar    = c;
                    lex_phase  = PH_EXP;
                end else begin
                    r.done = 1'b1;
                    r.err  = E_EXPECT_DIGIT;
                end
            end
        endcase
        r.kind   = lex_kind;
        r.sgn    = lex_flags[F_SIGNED];
        r.sized  = lex_flags[F_SIZE];
        r.based  = lex_flags[F_BASE];
        r.valued = lex_flags[F_VALUE];
        // a finished literal leaves nothing behind
        if (r.done) begin
            lex_phase      = PH_START;
            lex_kind       = K_UNKNOWN;
            lex_flags      = 4'h0;
            lex_first_let  = 1'b0;
            lex_first_zero = 1'b0;
            lex_value_cnt  = 2'd0;
            lex_value_xz   = 1'b0;
        end
        return r;
    endfunction

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side ready, with random stalls and requested long holds
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_requests != holds_served) begin
            i_ready      <= 1'b0;
            hold_left    <= HOLD_CYCLES - 1;
            holds_served <= holds_served + 1;
        end else if (!idle_on) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= 13);
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_lex_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no character outstanding");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("consumed", want.consumed, o_consumed);
                check_field("role", want.role, o_role);
                check_field("value_char", want.vchar, o_value_char);
                check_field("done_res", want.done, o_done_res);
                check_field("error_code", want.err, o_error_code);
                check_field("kind", want.kind, o_kind);
                check_field("is_signed", want.sgn, o_is_signed);
                check_field("has_size", want.sized, o_has_size);
                check_field("has_base", want.based, o_has_base);
                check_field("has_value", want.valued, o_has_value);
                results_seen++;
                if (o_done_res)
                    literals_done++;
                if (o_error_code != E_OK)
                    literals_error++;
            end
        end
    end

    // offer one character and wait for its transfer
    task automatic send_char(input logic [7:0] c, input logic ended);
        while (idle_on && $urandom_range(99) < 13) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_char_in <= c;
        i_at_end  <= ended;
        do
            @(posedge i_clk);
        while (!o_ready);
        pending_results.push_back(predict_lex_result(c, ended));
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i], 1'b0);
    endtask

    // write the strict-check register once the lexer has drained
    task automatic set_strict(input logic v);
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        strict_mode = v;
        strict_writes++;
    endtask

    function automatic logic [7:0] pick_char(input string set);
        return set[$urandom_range(set.len() - 1)];
    endfunction

    // one literal: mostly well formed, some mutated, some plain noise
    task automatic send_random_literal();
        logic [7:0] txt[$];
        string      digit_set;
        int         shape;
        shape = $urandom_range(9);
        if (shape < 3) begin
            // decimal, or real when shape is 2
            txt.push_back(pick_char("0123456789"));
            repeat ($urandom_range(3)) txt.push_back(pick_char("0123456789_"));
            if ($urandom_range(7) == 0)
                txt.push_back(pick_char("abcdefABCDEF"));
            if (shape == 2) begin
                txt.push_back(CH_DOT);
                repeat ($urandom_range(1, 3)) txt.push_back(pick_char("01234567899_"));
                if ($urandom_range(1) == 1) begin
                    txt.push_back(pick_char("eE"));
                    if ($urandom_range(1) == 1)
                        txt.push_back(pick_char("+-"));
                    repeat ($urandom_range(1, 3)) txt.push_back(pick_char("0123456789"));
                end
            end
        end else if (shape < 8) begin
            // based value, optionally sized
            if ($urandom_range(2) != 0) begin
                txt.push_back(($urandom_range(9) == 0) ? "0" : pick_char("123456789"));
                repeat ($urandom_range(2)) txt.push_back(pick_char("0123456789"));
                if ($urandom_range(7) == 0)
                    txt.push_back(pick_char("abcdef"));
                if ($urandom_range(3) == 0)
                    txt.push_back(pick_char(" \t"));
            end
            txt.push_back(CH_QUOTE);
            if ($urandom_range(2) == 0)
                txt.push_back(pick_char("sS"));
            case ($urandom_range(3))
                0: begin
                    txt.push_back(pick_char("dD"));
                    digit_set = "0123456789";
                end
                1: begin
                    txt.push_back(pick_char("bB"));
                    digit_set = "01";
                end
                2: begin
                    txt.push_back(pick_char("oO"));
                    digit_set = "01234567";
                end
                default: begin
                    txt.push_back(pick_char("hH"));
                    digit_set = "0123456789abcdefABCDEF";
                end
            endcase
            if ($urandom_range(4) == 0)
                txt.push_back(pick_char(" \t"));
            repeat ($urandom_range(6)) begin
                case ($urandom_range(9))
                    0:       txt.push_back(CH_UNDER);
                    1, 2:    txt.push_back(pick_char("xXzZ?"));
                    3:       txt.push_back(pick_char("0123456789abcdefABCDEF"));
                    default: txt.push_back(pick_char(digit_set));
                endcase
            end
        end else begin
            repeat ($urandom_range(1, 5)) txt.push_back(8'($urandom_range(255)));
        end
        // occasional corruption
        if ($urandom_range(6) == 0)
            txt[$urandom_range(txt.size() - 1)] = 8'($urandom_range(255));
        foreach (txt[i])
            send_char(txt[i], 1'b0);
        case ($urandom_range(5))
            0:       send_char(8'($urandom_range(255)), 1'b1);
            1:       send_char(8'($urandom_range(255)), 1'b0);
            default: send_char(pick_char(" \t\n\v\f\015;,)"), 1'b0);
        endcase
    endtask

    task automatic send_random_until(input int target);
        while (chars_sent < target)
            send_random_literal();
    endtask

    // real with plus exponent sign, high code, end of text, missing value
    task automatic test_directed_lenient();
        set_strict(1'b0);
        send_text("1.5e+3");
        send_char(8'hFF, 1'b0);
        send_char(8'hA5, 1'b1);
        send_text("'d");
        send_char(8'h00, 1'b1);
    endtask

    // space after a size, strict missing value, decimal x/z, signed sized hex
    task automatic test_directed_strict();
        set_strict(1'b1);
        send_text("7 ;");
        send_text("'d");
        send_char(8'h5A, 1'b1);
        send_text("'dzz ");
        send_text("8'sHf?");
        send_char(8'h00, 1'b1);
    endtask

    // random literals across both strictness settings
    task automatic test_random_literals();
        for (int p = 0; p < 4; p++) begin
            set_strict(p[0]);
            send_random_until(chars_sent + 250);
        end
    endtask

    // long receiver hold while characters keep coming
    task automatic test_back_pressure();
        set_strict(1'b1);
        hold_requests++;
        send_random_until(chars_sent + 60);
    endtask

    // full rate both sides
    task automatic test_full_rate();
        set_strict(1'b0);
        idle_on = 1'b0;
        send_random_until(chars_sent + 200);
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_lenient();
        test_directed_strict();
        test_random_literals();
        test_back_pressure();
        test_full_rate();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("lexer: %0d characters, %0d results checked, %0d strict-check writes",
                 chars_sent, results_seen, strict_writes);
        $display("lexer: %0d literals ended, %0d of them with an error code",
                 literals_done, literals_error);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
